// ===== sv/pba_pkg.sv =====
// Shared types, constants and saturation helper for the particle bounds accumulator.
`timescale 1ns / 1ps

package pba_pkg;

    // Q16.16 limits and constants
    localparam logic signed [31:0] Q_MAX    = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN    = 32'sh8000_0000;
    localparam logic signed [31:0] Q_ONE    = 32'sd65536;
    localparam logic signed [31:0] Q_TWENTY = 32'sd1310720;
    // sqrt(2) in Q16.16, and the rounding half for a drop of 16 fraction bits
    localparam logic signed [49:0] Q_SQRT2  = 50'sd92682;
    localparam logic signed [49:0] Q_HALF   = 50'sd32768;

    localparam int CFG_IDX_W = 1;

    // Extent modes (the unused code behaves as point mode)
    typedef enum logic [1:0] {
        MODE_POINT  = 2'd0,
        MODE_RADIUS = 2'd1,
        MODE_SIZE   = 2'd2
    } ext_mode_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXTENT_MODE = 1'b0,
        CFG_TIME_STEP   = 1'b1
    } cfg_idx_t;

    // Action codes
    localparam logic ACT_START    = 1'b0;
    localparam logic ACT_PARTICLE = 1'b1;

    // One accepted input beat
    typedef struct packed {
        logic               action;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] radius;
        logic signed [31:0] width;
        logic signed [31:0] height;
        logic signed [31:0] age;
        logic               last;
    } in_item_t;

    // Item after extent and age have been worked out
    typedef struct packed {
        logic               action;
        logic               both;        // radius mode: both pos+e and pos-e feed min and max
        logic               raise;       // extent competes for the largest extent
        logic               point_last;  // point mode on the final particle
        logic               done;
        logic signed [31:0] new_age;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] extent;
    } ext_item_t;

    // Saturate a 34-bit signed value to Q16.16
    function automatic logic signed [31:0] sat_q(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'(Q_MAX))
            r = Q_MAX;
        else if (v < 34'(Q_MIN))
            r = Q_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ===== sv/particle_bounds_accumulator_top.sv =====
// Top level of the particle bounds accumulator: config registers, input stage, handshakes.
//
//   Channel  Signals                      Direction  Moves
//   in       in_valid / in_stall          sink       one particle or start beat
//   out      out_valid / out_stall        source     one result beat per input beat
//   cfg      cfg_valid / cfg_ready        sink       one register write per beat
//
// One beat enters per cycle while in_stall is low and passes through the input register,
// extent register (multiply by sqrt(2), size sum or one), then the box and extent
// accumulators whose state is the result register.
// Reset clears all stage valids, sets the box to empty, the largest extent to
// the most negative value and both registers to zero.
// An output stall holds the result and any stage whose next is full; empty stages fill.
// Configuration writes are always ready.
`timescale 1ns / 1ps

module particle_bounds_accumulator_top (
    input  logic                           clk,
    input  logic                           rst_n,
    // input channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           action,
    input  logic signed [31:0]             pos_x,
    input  logic signed [31:0]             pos_y,
    input  logic signed [31:0]             pos_z,
    input  logic signed [31:0]             radius,
    input  logic signed [31:0]             width,
    input  logic signed [31:0]             height,
    input  logic signed [31:0]             age,
    input  logic                           last,
    // output channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [31:0]             new_age,
    output logic signed [31:0]             min_x,
    output logic signed [31:0]             min_y,
    output logic signed [31:0]             min_z,
    output logic signed [31:0]             max_x,
    output logic signed [31:0]             max_y,
    output logic signed [31:0]             max_z,
    output logic signed [31:0]             max_extent,
    output logic                           batch_done,
    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                    cfg_data
);
    import pba_pkg::*;

    logic               point_mode;
    logic [1:0]         mode_reg;
    logic signed [31:0] time_step_reg;

    logic               a_valid_reg;
    logic               a_valid_next;
    in_item_t           a_item_reg;
    in_item_t           in_item;

    logic               b_valid;
    ext_item_t          b_item;
    logic               out_free;
    logic               b_free;
    logic               b_move;
    logic               a_move;
    logic               in_take;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_POINT;
            time_step_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_EXTENT_MODE: mode_reg      <= cfg_data[1:0];
                CFG_TIME_STEP:   time_step_reg <= cfg_data;
                default:         mode_reg      <= mode_reg;
            endcase
        end
    end

    // Flag kept for the point-mode check below
    assign point_mode = (mode_reg != MODE_RADIUS) && (mode_reg != MODE_SIZE);

    // Advance chain: a stage moves on when the next one is empty or moving
    assign out_free = !out_valid || !out_stall;
    assign b_move   = b_valid && out_free;
    assign b_free   = !b_valid || out_free;
    assign a_move   = a_valid_reg && b_free;
    assign in_stall = a_valid_reg && !b_free;
    assign in_take  = in_valid && !in_stall;

    // Input register
    always_comb
    begin
        in_item.action = action;
        in_item.pos_x  = pos_x;
        in_item.pos_y  = pos_y;
        in_item.pos_z  = pos_z;
        in_item.radius = radius;
        in_item.width  = width;
        in_item.height = height;
        in_item.age    = age;
        in_item.last   = last;
    end

    always_comb
    begin
        if (in_take)
            a_valid_next = 1'b1;
        else if (a_move)
            a_valid_next = 1'b0;
        else
            a_valid_next = a_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else
            a_valid_reg <= a_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            a_item_reg <= in_item;
    end

    pba_extent_unit u_extent (
        .clk         (clk),
        .rst_n       (rst_n),
        .extent_mode (mode_reg),
        .time_step   (time_step_reg),
        .a_item      (a_item_reg),
        .a_move      (a_move),
        .b_move      (b_move),
        .b_valid     (b_valid),
        .b_item      (b_item)
    );

    pba_bounds_unit u_bounds (
        .clk         (clk),
        .rst_n       (rst_n),
        .b_item      (b_item),
        .b_move      (b_move),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .new_age     (new_age),
        .min_x       (min_x),
        .min_y       (min_y),
        .min_z       (min_z),
        .max_x       (max_x),
        .max_y       (max_y),
        .max_z       (max_z),
        .max_extent  (max_extent),
        .batch_done  (batch_done)
    );

    // A start beat leaves the box empty and the extent at its floor
    assert property (@(posedge clk) disable iff (!rst_n)
        b_move && b_item.action == ACT_START |=>
            min_x == Q_MAX && max_z == Q_MIN && max_extent == Q_MIN)
        else $error("start beat did not clear the bounds");

    // A final point particle leaves the largest extent at twenty or more
    assert property (@(posedge clk) disable iff (!rst_n)
        b_move && b_item.action == ACT_PARTICLE && b_item.point_last |=>
            max_extent >= Q_TWENTY)
        else $error("largest extent below twenty after final point particle");

    // Every beat handed to the accumulators shows up as a result
    assert property (@(posedge clk) disable iff (!rst_n)
        b_move |=> out_valid)
        else $error("accumulated beat lost before the result register");

    // An empty input register never stalls the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !a_valid_reg |-> !in_stall)
        else $error("input stalled with an empty input register");

    // Point-mode extent is always one
    assert property (@(posedge clk) disable iff (!rst_n)
        a_move && point_mode |=> b_item.extent == Q_ONE)
        else $error("point-mode extent is not one");

endmodule

// ===== sv/pba_extent_unit.sv =====
// First work stage: particle extent, aged time and the extent register stage.
`timescale 1ns / 1ps

module pba_extent_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         extent_mode,
    input  logic signed [31:0] time_step,
    input  pba_pkg::in_item_t  a_item,
    input  logic               a_move,
    input  logic               b_move,
    output logic               b_valid,
    output pba_pkg::ext_item_t b_item
);
    import pba_pkg::*;

    logic               b_valid_reg;
    logic               b_valid_next;
    ext_item_t          b_item_reg;
    ext_item_t          b_item_next;

    logic signed [49:0] rad_prod;
    logic signed [49:0] rad_round;
    logic signed [31:0] rad_ext;
    logic signed [33:0] size_sum;
    logic signed [31:0] size_ext;
    logic signed [33:0] age_sum;
    logic signed [31:0] ext_sel;
    logic               both_sel;
    logic               raise_sel;

    // Radius times sqrt(2), rounded half up, saturated
    assign rad_prod  = $signed({{18{a_item.radius[31]}}, a_item.radius}) * Q_SQRT2;
    assign rad_round = rad_prod + Q_HALF;
    assign rad_ext   = sat_q(rad_round[49:16]);

    // Half the smaller dimension plus the larger one
    always_comb
    begin
        if (a_item.width <= a_item.height)
            size_sum = 34'(a_item.width >>> 1) + 34'(a_item.height);
        else
            size_sum = 34'(a_item.height >>> 1) + 34'(a_item.width);
    end
    assign size_ext = sat_q(size_sum);

    // Aged time
    assign age_sum = 34'(a_item.age) + 34'(time_step);

    // Pick the extent by mode
    always_comb
    begin
        case (extent_mode)
            MODE_RADIUS:
            begin
                ext_sel   = rad_ext;
                both_sel  = 1'b1;
                raise_sel = 1'b1;
            end
            MODE_SIZE:
            begin
                ext_sel   = size_ext;
                both_sel  = 1'b0;
                raise_sel = 1'b1;
            end
            default:
            begin
                ext_sel   = Q_ONE;
                both_sel  = 1'b0;
                raise_sel = 1'b0;
            end
        endcase
    end

    // Assemble the next stage item
    always_comb
    begin
        b_item_next.action     = a_item.action;
        b_item_next.both       = both_sel;
        b_item_next.raise      = raise_sel;
        b_item_next.point_last = !raise_sel && a_item.last;
        b_item_next.pos_x      = a_item.pos_x;
        b_item_next.pos_y      = a_item.pos_y;
        b_item_next.pos_z      = a_item.pos_z;
        b_item_next.extent     = ext_sel;
        if (a_item.action == ACT_PARTICLE)
        begin
            b_item_next.new_age = sat_q(age_sum);
            b_item_next.done    = a_item.last;
        end
        else
        begin
            b_item_next.new_age = '0;
            b_item_next.done    = 1'b0;
        end
    end

    // Stage occupancy: fill on load, drain on hand-on
    always_comb
    begin
        if (a_move)
            b_valid_next = 1'b1;
        else if (b_move)
            b_valid_next = 1'b0;
        else
            b_valid_next = b_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else
            b_valid_reg <= b_valid_next;
    end

    // Hold the payload unless a new beat loads
    always_ff @(posedge clk)
    begin
        if (a_move)
            b_item_reg <= b_item_next;
    end

    assign b_valid = b_valid_reg;
    assign b_item  = b_item_reg;

endmodule

// ===== sv/pba_bounds_unit.sv =====
// Second work stage: box and largest-extent accumulation and the result register.
`timescale 1ns / 1ps

module pba_bounds_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  pba_pkg::ext_item_t b_item,
    input  logic               b_move,
    input  logic               out_stall,
    output logic               out_valid,
    output logic signed [31:0] new_age,
    output logic signed [31:0] min_x,
    output logic signed [31:0] min_y,
    output logic signed [31:0] min_z,
    output logic signed [31:0] max_x,
    output logic signed [31:0] max_y,
    output logic signed [31:0] max_z,
    output logic signed [31:0] max_extent,
    output logic               batch_done
);
    import pba_pkg::*;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic signed [31:0] new_age_reg;
    logic               done_reg;

    // Box state doubles as the result fields: it moves only when the result is free
    logic signed [31:0] lo_reg  [3];
    logic signed [31:0] hi_reg  [3];
    logic signed [31:0] lo_next [3];
    logic signed [31:0] hi_next [3];
    logic signed [31:0] ext_reg;
    logic signed [31:0] ext_next;

    logic signed [31:0] pos     [3];
    logic signed [31:0] plus    [3];
    logic signed [31:0] minus   [3];
    logic signed [31:0] lo_cand [3];
    logic signed [31:0] hi_cand [3];

    assign pos[0] = b_item.pos_x;
    assign pos[1] = b_item.pos_y;
    assign pos[2] = b_item.pos_z;

    // Grow each axis by the particle's extent; a start beat empties the box
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            plus[i]  = sat_q(34'(pos[i]) + 34'(b_item.extent));
            minus[i] = sat_q(34'(pos[i]) - 34'(b_item.extent));
            if (b_item.both)
            begin
                lo_cand[i] = (plus[i] < minus[i]) ? plus[i] : minus[i];
                hi_cand[i] = (plus[i] > minus[i]) ? plus[i] : minus[i];
            end
            else
            begin
                lo_cand[i] = minus[i];
                hi_cand[i] = plus[i];
            end
            if (b_item.action == ACT_START)
            begin
                lo_next[i] = Q_MAX;
                hi_next[i] = Q_MIN;
            end
            else
            begin
                lo_next[i] = (lo_cand[i] < lo_reg[i]) ? lo_cand[i] : lo_reg[i];
                hi_next[i] = (hi_cand[i] > hi_reg[i]) ? hi_cand[i] : hi_reg[i];
            end
        end
    end

    // Largest extent: reset on start, else raise to extent, or twenty at last point
    always_comb
    begin
        ext_next = ext_reg;
        if (b_item.action == ACT_START)
            ext_next = Q_MIN;
        else if (b_item.raise)
        begin
            if (b_item.extent > ext_reg)
                ext_next = b_item.extent;
        end
        else if (b_item.point_last && ext_reg < Q_TWENTY)
            ext_next = Q_TWENTY;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                lo_reg[i] <= Q_MAX;
                hi_reg[i] <= Q_MIN;
            end
            ext_reg <= Q_MIN;
        end
        else if (b_move)
        begin
            for (int i = 0; i < 3; i++)
            begin
                lo_reg[i] <= lo_next[i];
                hi_reg[i] <= hi_next[i];
            end
            ext_reg <= ext_next;
        end
    end

    // Result occupancy: fill on a new beat, drop once taken
    always_comb
    begin
        if (b_move)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (b_move)
        begin
            new_age_reg <= b_item.new_age;
            done_reg    <= b_item.done;
        end
    end

    assign out_valid  = out_valid_reg;
    assign new_age    = new_age_reg;
    assign batch_done = done_reg;
    assign min_x      = lo_reg[0];
    assign min_y      = lo_reg[1];
    assign min_z      = lo_reg[2];
    assign max_x      = hi_reg[0];
    assign max_y      = hi_reg[1];
    assign max_z      = hi_reg[2];
    assign max_extent = ext_reg;

endmodule
